// ===== hdl/srf_pkg.sv =====
package srf_pkg;

  localparam int WORD_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int IO_W       = 32;
  localparam int ITER_W     = 10;
  localparam int TOL_W      = 31;
  localparam int OFFC_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 10'd20;
  localparam logic [TOL_W-1:0]  TOL_RST      = 31'd66;
  localparam logic [OFFC_W-1:0] OFFC_RST     = 31'd262144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER  = 2'd0,
    REG_TOLERANCE = 2'd1,
    REG_OFFSET    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_CONVERGED   = 2'd0,
    STAT_SMALL_DENOM = 2'd1,
    STAT_LIMIT       = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ0_WAIT,
    ST_SQ1,
    ST_SQ1_WAIT,
    ST_CHECK,
    ST_MUL_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_cmd_t;

  typedef struct packed {
    logic              done;
    status_t           status;
    logic [ITER_W-1:0] used;
  } srf_info_t;

endpackage

// ===== hdl/srf_mdu.sv =====
// Shared bit-serial multiply / divide unit built round one adder.
// MUL: a * b, W steps. DIV: held product / divisor, 2W steps, restoring.
module srf_mdu #(
  parameter int W = srf_pkg::WORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  srf_pkg::mdu_cmd_t cmd,
  input  logic [W-1:0]     op_a,
  input  logic [W-1:0]     op_b,
  input  logic [W-1:0]     divisor,
  output logic             done,
  output logic [2*W-1:0]   prod,
  output logic [2*W-1:0]   quot
);

  localparam int PW   = 2 * W;
  localparam int CNTW = $clog2(PW + 1);

  logic [W-1:0]      hi_r, hi_nxt;
  logic [PW-1:0]     lo_r, lo_nxt;
  logic [W-1:0]      a_r, a_nxt;
  srf_pkg::mdu_op_t  op_r, op_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  logic              sub;
  logic [W:0]        add_x;
  logic [W+1:0]      add_y;
  logic [W+1:0]      sum;
  logic              ge;

  // one adder: accumulate for MUL, trial subtract for DIV
  always_comb begin
    sub   = (op_r == srf_pkg::OP_DIV);
    if (sub) begin
      add_x = {hi_r, lo_r[PW-1]};
      add_y = {2'b00, a_r};
    end else begin
      add_x = {1'b0, hi_r};
      add_y = lo_r[0] ? {2'b00, a_r} : '0;
    end
    sum = {1'b0, add_x} + (sub ? ~add_y : add_y) + (W+2)'(sub);
    ge  = ~sum[W+1];
  end

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    a_nxt    = a_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      op_nxt  = cmd.op;
      run_nxt = 1'b1;
      hi_nxt  = '0;
      if (cmd.op == srf_pkg::OP_DIV) begin
        lo_nxt  = {hi_r, lo_r[W-1:0]};
        a_nxt   = divisor;
        cnt_nxt = CNTW'(PW);
      end else begin
        lo_nxt  = {{W{1'b0}}, op_b};
        a_nxt   = op_a;
        cnt_nxt = CNTW'(W);
      end
    end else if (run_r) begin
      if (sub) begin
        hi_nxt = ge ? sum[W-1:0] : add_x[W-1:0];
        lo_nxt = {lo_r[PW-2:0], ge};
      end else begin
        hi_nxt = sum[W:1];
        lo_nxt = {lo_r[PW-1:W], sum[0], lo_r[W-1:1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= srf_pkg::OP_MUL;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    a_r  <= a_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r[W-1:0]};
  assign quot = lo_r;

endmodule

// ===== hdl/srf_seq.sv =====
// Secant sequencer: saturating arithmetic around the shared mul/div unit.
module srf_seq #(
  parameter int W = srf_pkg::WORD_WIDTH_DEF,
  parameter int F = srf_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [W-1:0]         x0_in,
  input  logic signed [W-1:0]         x1_in,
  input  logic signed [W-1:0]         c,
  input  logic [srf_pkg::TOL_W-1:0]   tol,
  input  logic [srf_pkg::ITER_W-1:0]  max_iter,
  output logic                        busy,
  output srf_pkg::srf_info_t          info,
  output logic signed [W-1:0]         root
);

  localparam int PW = 2 * W;
  localparam int CW = (W > srf_pkg::TOL_W) ? W : srf_pkg::TOL_W;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic [W:0] e;
    e = {a[W-1], a} - {b[W-1], b};
    if (e[W] != e[W-1]) ssub = e[W] ? MINV : MAXV;
    else ssub = e[W-1:0];
  endfunction

  function automatic logic [W-1:0] magof(input logic signed [W-1:0] a);
    magof = a[W-1] ? (~a + 1'b1) : a;
  endfunction

  srf_pkg::state_t state_r, state_nxt;

  logic signed [W-1:0]        x0_r, x0_nxt, x1_r, x1_nxt;
  logic signed [W-1:0]        f0_r, f0_nxt, f1_r, f1_nxt;
  logic signed [W-1:0]        t_r, t_nxt;
  logic [W-1:0]               dm_r, dm_nxt;
  logic                       neg_r, neg_nxt;
  logic [srf_pkg::ITER_W-1:0] iter_r, iter_nxt;
  srf_pkg::status_t           status_r, status_nxt;

  srf_pkg::mdu_cmd_t          mdu_cmd;
  logic [W-1:0]               mdu_a, mdu_b;
  logic                       mdu_done;
  logic [PW-1:0]              mdu_prod, mdu_quot;

  logic [PW-1:0]              sq_sh;
  logic signed [W-1:0]        sq_sat, fsq;
  logic signed [W-1:0]        chk_d, chk_diff;
  logic [W-1:0]               chk_dm;
  logic                       chk_small, chk_neg;
  logic                       q_big;
  logic signed [W-1:0]        t_val, step_x2;
  logic                       step_conv;

  srf_mdu #(.W(W)) u_mdu (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mdu_cmd),
    .op_a    (mdu_a),
    .op_b    (mdu_b),
    .divisor (dm_r),
    .done    (mdu_done),
    .prod    (mdu_prod),
    .quot    (mdu_quot)
  );

  always_comb begin
    // square: magnitude truncated, then f = x*x - c
    sq_sh  = mdu_prod >> F;
    sq_sat = (|sq_sh[PW-1:W-1]) ? MAXV : sq_sh[W-1:0];
    fsq    = ssub(sq_sat, c);

    chk_d     = ssub(f1_r, f0_r);
    chk_dm    = magof(chk_d);
    chk_small = (CW'(chk_dm) < CW'(tol)) || (chk_dm == '0);
    chk_diff  = ssub(x1_r, x0_r);
    chk_neg   = f1_r[W-1] ^ chk_diff[W-1] ^ chk_d[W-1];

    q_big = |mdu_quot[PW-1:W-1];
    if (neg_r) t_val = q_big ? MINV : -mdu_quot[W-1:0];
    else t_val = q_big ? MAXV : mdu_quot[W-1:0];

    step_x2   = ssub(x1_r, t_r);
    step_conv = CW'(magof(ssub(step_x2, x1_r))) < CW'(tol);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srf_pkg::ST_IDLE: begin
        if (start) state_nxt = (max_iter == '0) ? srf_pkg::ST_DONE : srf_pkg::ST_SQ0;
      end
      srf_pkg::ST_SQ0:      state_nxt = srf_pkg::ST_SQ0_WAIT;
      srf_pkg::ST_SQ0_WAIT: if (mdu_done) state_nxt = srf_pkg::ST_SQ1;
      srf_pkg::ST_SQ1:      state_nxt = srf_pkg::ST_SQ1_WAIT;
      srf_pkg::ST_SQ1_WAIT: if (mdu_done) state_nxt = srf_pkg::ST_CHECK;
      srf_pkg::ST_CHECK: begin
        state_nxt = chk_small ? srf_pkg::ST_DONE : srf_pkg::ST_MUL_WAIT;
      end
      srf_pkg::ST_MUL_WAIT: if (mdu_done) state_nxt = srf_pkg::ST_DIV;
      srf_pkg::ST_DIV:      state_nxt = srf_pkg::ST_DIV_WAIT;
      srf_pkg::ST_DIV_WAIT: if (mdu_done) state_nxt = srf_pkg::ST_STEP;
      srf_pkg::ST_STEP: begin
        if (step_conv || iter_r == max_iter) state_nxt = srf_pkg::ST_DONE;
        else state_nxt = srf_pkg::ST_SQ1;
      end
      srf_pkg::ST_DONE:     state_nxt = srf_pkg::ST_IDLE;
      default:              state_nxt = srf_pkg::ST_IDLE;
    endcase
  end

  // unit commands and status outputs
  always_comb begin
    mdu_cmd.start = 1'b0;
    mdu_cmd.op    = srf_pkg::OP_MUL;
    mdu_a         = magof(x1_r);
    mdu_b         = magof(x1_r);
    unique case (state_r)
      srf_pkg::ST_SQ0: begin
        mdu_cmd.start = 1'b1;
        mdu_a         = magof(x0_r);
        mdu_b         = magof(x0_r);
      end
      srf_pkg::ST_SQ1: mdu_cmd.start = 1'b1;
      srf_pkg::ST_CHECK: begin
        mdu_cmd.start = ~chk_small;
        mdu_a         = magof(f1_r);
        mdu_b         = magof(chk_diff);
      end
      srf_pkg::ST_DIV: begin
        mdu_cmd.start = 1'b1;
        mdu_cmd.op    = srf_pkg::OP_DIV;
      end
      default: begin
      end
    endcase
    busy        = (state_r != srf_pkg::ST_IDLE);
    info.done   = (state_r == srf_pkg::ST_DONE);
    info.status = status_r;
    info.used   = iter_r;
    root        = x1_r;
  end

  // datapath
  always_comb begin
    x0_nxt     = x0_r;
    x1_nxt     = x1_r;
    f0_nxt     = f0_r;
    f1_nxt     = f1_r;
    t_nxt      = t_r;
    dm_nxt     = dm_r;
    neg_nxt    = neg_r;
    iter_nxt   = iter_r;
    status_nxt = status_r;
    case (state_r)
      srf_pkg::ST_IDLE: begin
        if (start) begin
          x0_nxt     = x0_in;
          x1_nxt     = x1_in;
          iter_nxt   = '0;
          status_nxt = srf_pkg::STAT_LIMIT;
        end
      end
      srf_pkg::ST_SQ0_WAIT: if (mdu_done) f0_nxt = fsq;
      srf_pkg::ST_SQ1_WAIT: if (mdu_done) f1_nxt = fsq;
      srf_pkg::ST_CHECK: begin
        iter_nxt = iter_r + 1'b1;
        dm_nxt   = chk_dm;
        neg_nxt  = chk_neg;
        if (chk_small) status_nxt = srf_pkg::STAT_SMALL_DENOM;
      end
      srf_pkg::ST_DIV_WAIT: if (mdu_done) t_nxt = t_val;
      srf_pkg::ST_STEP: begin
        x1_nxt = step_x2;
        if (step_conv) begin
          status_nxt = srf_pkg::STAT_CONVERGED;
        end else begin
          // old x1 becomes x0, so its f value carries over
          x0_nxt = x1_r;
          f0_nxt = f1_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= srf_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    x0_r     <= x0_nxt;
    x1_r     <= x1_nxt;
    f0_r     <= f0_nxt;
    f1_r     <= f1_nxt;
    t_r      <= t_nxt;
    dm_r     <= dm_nxt;
    neg_r    <= neg_nxt;
    iter_r   <= iter_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== hdl/secant_root_finder.sv =====
// Secant root finder for f(x) = x*x - c, signed fixed point.
// Input: a word of two guesses is taken at a clock edge with start high and
// busy low. busy stays high until the result has been shown.
// Output: one result word per input, held on the out_ ports for exactly one
// cycle with out_valid high. There is no back-pressure; the receiver must
// take it in that cycle.
// Config: cfg_valid/cfg_ready write channel, cfg_index selects max_iterations,
// tolerance or offset_constant. cfg_ready is always high; write only when
// idle. Unknown indexes are ignored.
// Sequence: one shared bit-serial mul/div unit does all the work. The first
// iteration adds a square of the first guess; each iteration then runs a
// square, a check, a product, a divide and a step in turn. The next word
// can be taken in the cycle after the result is shown, so words are handled
// one at a time; a small denominator stops at the check and cuts the last
// iteration short.
// Reset: synchronous, active low; registers go to 20, 66 and 4.0, and the
// block comes up idle.
module secant_root_finder #(
  parameter int WORD_WIDTH    = srf_pkg::WORD_WIDTH_DEF,
  parameter int FRACTION_BITS = srf_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [srf_pkg::IO_W-1:0]  in_guess_first,
  input  logic signed [srf_pkg::IO_W-1:0]  in_guess_second,
  output logic                             out_valid,
  output logic signed [srf_pkg::IO_W-1:0]  out_root_estimate,
  output logic [1:0]                       out_status,
  output logic [srf_pkg::ITER_W-1:0]       out_iterations_used,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int W  = WORD_WIDTH;
  localparam int IW = srf_pkg::IO_W;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [srf_pkg::ITER_W-1:0] max_iter_r;
  logic [srf_pkg::TOL_W-1:0]  tol_r;
  logic [srf_pkg::OFFC_W-1:0] offc_r;

  logic                busy_i, go;
  logic signed [W-1:0] x0_w, x1_w, c_w, root_w;
  srf_pkg::srf_info_t  info;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= srf_pkg::MAX_ITER_RST;
      tol_r      <= srf_pkg::TOL_RST;
      offc_r     <= srf_pkg::OFFC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srf_pkg::REG_MAX_ITER:  max_iter_r <= cfg_data[srf_pkg::ITER_W-1:0];
        srf_pkg::REG_TOLERANCE: tol_r      <= cfg_data[srf_pkg::TOL_W-1:0];
        srf_pkg::REG_OFFSET:    offc_r     <= cfg_data[srf_pkg::OFFC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // port words to internal word width, saturating when narrower
  generate
    if (W >= IW) begin : g_wide_in
      assign x0_w = W'(in_guess_first);
      assign x1_w = W'(in_guess_second);
    end else begin : g_narrow_in
      always_comb begin
        if (!in_guess_first[IW-1] && |in_guess_first[IW-2:W-1]) x0_w = MAXV;
        else if (in_guess_first[IW-1] && !(&in_guess_first[IW-2:W-1])) x0_w = MINV;
        else x0_w = in_guess_first[W-1:0];
        if (!in_guess_second[IW-1] && |in_guess_second[IW-2:W-1]) x1_w = MAXV;
        else if (in_guess_second[IW-1] && !(&in_guess_second[IW-2:W-1])) x1_w = MINV;
        else x1_w = in_guess_second[W-1:0];
      end
    end

    if (W > srf_pkg::OFFC_W) begin : g_wide_c
      assign c_w = W'(offc_r);
    end else begin : g_narrow_c
      assign c_w = (|offc_r[srf_pkg::OFFC_W-1:W-1]) ? MAXV : offc_r[W-1:0];
    end

    if (W <= IW) begin : g_narrow_out
      assign out_root_estimate = IW'(root_w);
    end else begin : g_wide_out
      always_comb begin
        if ((&root_w[W-1:IW-1]) || !(|root_w[W-1:IW-1]))
          out_root_estimate = root_w[IW-1:0];
        else
          out_root_estimate = root_w[W-1] ? {1'b1, {(IW-1){1'b0}}}
                                          : {1'b0, {(IW-1){1'b1}}};
      end
    end
  endgenerate

  assign go   = start & ~busy_i;
  assign busy = busy_i;

  srf_seq #(.W(W), .F(FRACTION_BITS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go),
    .x0_in    (x0_w),
    .x1_in    (x1_w),
    .c        (c_w),
    .tol      (tol_r),
    .max_iter (max_iter_r),
    .busy     (busy_i),
    .info     (info),
    .root     (root_w)
  );

  assign out_valid           = info.done;
  assign out_status          = info.status;
  assign out_iterations_used = info.used;

endmodule

// ===== verif/tb_secant_root_finder.sv =====
module tb_secant_root_finder;

  localparam int       IO_W        = srf_pkg::IO_W;
  localparam int       ITER_W      = srf_pkg::ITER_W;
  localparam int       TOL_W       = srf_pkg::TOL_W;
  localparam int       OFFC_W      = srf_pkg::OFFC_W;
  localparam int       CFG_IDX_W   = srf_pkg::CFG_IDX_W;
  localparam int       CFG_DATA_W  = srf_pkg::CFG_DATA_W;
  localparam int       ONE         = 1 << srf_pkg::FRACTION_BITS_DEF;
  localparam longint   WMAX        = 64'sd2147483647;
  localparam longint   WMIN        = -64'sd2147483648;
  localparam int       CYCLE_LIMIT = 15_000_000;
  localparam int       ITEM_COUNT  = 600;
  localparam int       PHASES      = 12;

  typedef struct {
    logic signed [IO_W-1:0] root;
    srf_pkg::status_t       status;
    logic [ITER_W-1:0]      used;
  } root_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IO_W-1:0] in_guess_first = '0;
  logic signed [IO_W-1:0] in_guess_second = '0;
  logic out_valid;
  logic signed [IO_W-1:0] out_root_estimate;
  logic [1:0] out_status;
  logic [ITER_W-1:0] out_iterations_used;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor's copy of the registers
  logic [ITER_W-1:0] iter_limit = srf_pkg::MAX_ITER_RST;
  logic [TOL_W-1:0]  tol_q      = srf_pkg::TOL_RST;
  logic [OFFC_W-1:0] offset_q   = srf_pkg::OFFC_RST;

  root_result_t pending_roots[$];
  root_result_t head_root;
  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  settings_used = 1;
  int  status_hits[3] = '{0, 0, 0};
  int  cycle_count = 0;
  bit  sender_gaps = 1'b1;

  secant_root_finder DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_guess_first      (in_guess_first),
    .in_guess_second     (in_guess_second),
    .out_valid           (out_valid),
    .out_root_estimate   (out_root_estimate),
    .out_status          (out_status),
    .out_iterations_used (out_iterations_used),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------- predictor ----------------

  function automatic longint clamp_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  function automatic longint mag(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // x*x in Q16.16, magnitude truncated, saturated positive
  function automatic longint square_q(longint x);
    bit [63:0] m;
    bit [63:0] p;
    m = mag(x);
    p = (m * m) >> srf_pkg::FRACTION_BITS_DEF;
    if (p > 64'h7FFF_FFFF) return WMAX;
    return longint'(p);
  endfunction

  function automatic longint curve_at(longint x, longint c);
    return sat_sub(square_q(x), c);
  endfunction

  // a*b/d exactly, truncated toward zero, saturated
  function automatic longint scaled_quot(longint a, longint b, longint d);
    bit [63:0] ma;
    bit [63:0] mb;
    bit [63:0] md;
    bit [63:0] quo;
    bit        neg;
    ma  = mag(a);
    mb  = mag(b);
    md  = mag(d);
    quo = (ma * mb) / md;
    neg = (a < 0) ^ (b < 0) ^ (d < 0);
    if (neg) return (quo >= 64'h8000_0000) ? WMIN : -longint'(quo);
    return (quo > 64'h7FFF_FFFF) ? WMAX : longint'(quo);
  endfunction

  function automatic root_result_t solve_secant(logic signed [IO_W-1:0] g0,
                                                logic signed [IO_W-1:0] g1);
    root_result_t r;
    longint x0;
    longint x1;
    longint x2;
    longint c;
    longint f1;
    longint d;
    longint dm;
    longint tol;
    bit     stop;
    x0   = longint'(g0);
    x1   = longint'(g1);
    c    = longint'(offset_q);
    tol  = longint'(tol_q);
    stop = 1'b0;
    r.status = srf_pkg::STAT_LIMIT;
    r.used   = '0;
    for (int i = 0; i < int'(iter_limit) && !stop; i++) begin
      f1 = curve_at(x1, c);
      d  = sat_sub(f1, curve_at(x0, c));
      dm = mag(d);
      r.used = ITER_W'(i + 1);
      if (dm < tol || dm == 0) begin
        r.status = srf_pkg::STAT_SMALL_DENOM;
        stop = 1'b1;
      end else begin
        x2 = sat_sub(x1, scaled_quot(f1, sat_sub(x1, x0), d));
        if (mag(sat_sub(x2, x1)) < tol) begin
          r.status = srf_pkg::STAT_CONVERGED;
          stop = 1'b1;
        end else begin
          x0 = x1;
        end
        x1 = x2;
      end
    end
    r.root = IO_W'(clamp_word(x1));
    return r;
  endfunction

  // ---------------- result checking ----------------

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_status <= 2'(srf_pkg::STAT_LIMIT)) status_hits[out_status]++;
      if (pending_roots.size() == 0) begin
        note_failure($sformatf("result word with nothing pending: root %0d status %0d used %0d",
                               out_root_estimate, out_status, out_iterations_used));
      end else begin
        head_root = pending_roots.pop_front();
        if (out_root_estimate !== head_root.root || out_status !== head_root.status ||
            out_iterations_used !== head_root.used)
          note_failure($sformatf(
            "mismatch: expected root %0d status %0d used %0d, got root %0d status %0d used %0d",
            head_root.root, head_root.status, head_root.used,
            out_root_estimate, out_status, out_iterations_used));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d results still pending", pending_roots.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- driving ----------------

  task automatic send_guesses(logic signed [IO_W-1:0] x0, logic signed [IO_W-1:0] x1);
    if (sender_gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start           <= 1'b1;
    in_guess_first  <= x0;
    in_guess_second <= x1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_roots.push_back(solve_secant(x0, x1));
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_roots.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_reg(srf_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      srf_pkg::REG_MAX_ITER:  iter_limit = value[ITER_W-1:0];
      srf_pkg::REG_TOLERANCE: tol_q      = value[TOL_W-1:0];
      srf_pkg::REG_OFFSET:    offset_q   = value[OFFC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(int its, logic [31:0] tol, logic [31:0] offs);
    write_reg(srf_pkg::REG_MAX_ITER, its);
    write_reg(srf_pkg::REG_TOLERANCE, tol);
    write_reg(srf_pkg::REG_OFFSET, offs);
    settings_used++;
  endtask

  function automatic logic signed [IO_W-1:0] pick_guess(int unsigned span);
    logic signed [IO_W-1:0] m;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0;
          3: return -32'sh1;
          default: return 32'sh1;
        endcase
      end
      default: begin
        m = $urandom_range(0, span);
        return $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  // ---------------- tests ----------------

  // reset settings: 20 iterations, tolerance 66, c = 4.0
  task automatic test_extreme_guesses();
    send_guesses(0, 0);
    send_guesses(ONE, 3 * ONE);
    send_guesses(-3 * ONE, -ONE);
    send_guesses(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_guesses(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_guesses(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_guesses(32'sh8000_0000, 32'sh8000_0001);
    send_guesses(-1, 1);
    send_guesses(2 * ONE, 2 * ONE + 1);
    send_guesses(0, 32'sh7FFF_FFFF);
    send_guesses(32'sh5555_5555, 32'shAAAA_AAAA);
  endtask

  task automatic test_limit_status();
    load_setting(1, 1, 4 * ONE);
    send_guesses(ONE, 3 * ONE);
    load_setting(2, 1, 4 * ONE);
    send_guesses(ONE, 3 * ONE);
    send_guesses(10 * ONE, 11 * ONE);
  endtask

  task automatic test_tolerance_extremes();
    // widest tolerance: almost every denominator counts as too small
    load_setting(20, 32'h7FFF_FFFF, 0);
    send_guesses(32'sh7FFF_FFFF, 0);
    send_guesses(ONE, 3 * ONE);
    load_setting(20, 1, 4 * ONE);
    send_guesses(ONE, 3 * ONE);
  endtask

  task automatic test_offset_extremes();
    load_setting(20, 66, 32'h7FFF_FFFF);
    send_guesses(100 * ONE, 200 * ONE);
    send_guesses(-ONE, 32'sh7FFF_FFFF);
    load_setting(20, 66, 0);
    send_guesses(ONE, 2 * ONE);
  endtask

  task automatic test_long_runs();
    load_setting(1023, 1, 0);
    send_guesses(ONE, 2 * ONE);
    send_guesses(3 * ONE, -3 * ONE);
    send_guesses(32'sh8000_0000, 32'sh7FFF_FFFF);
  endtask

  task automatic test_random_phases();
    int          its;
    logic [31:0] tol;
    logic [31:0] offs;
    int unsigned span;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: its = $urandom_range(1, 12);
        6, 7, 8:          its = $urandom_range(13, 40);
        default:          its = 20;
      endcase
      case ($urandom_range(0, 3))
        0:       tol = $urandom_range(1, 4);
        1:       tol = $urandom_range(1, 1024);
        2:       tol = $urandom_range(1, 65536);
        default: tol = $urandom_range(1, 32'h7FFF_FFFF);
      endcase
      case ($urandom_range(0, 3))
        0:       offs = 4 * ONE;
        1:       offs = $urandom_range(0, 100) << srf_pkg::FRACTION_BITS_DEF;
        2:       offs = $urandom & 32'h7FFF_FFFF;
        default: offs = $urandom_range(0, ONE - 1);
      endcase
      span = (offs > 1024 * ONE) ? 512 * ONE : 32 * ONE;
      load_setting(its, tol, offs);
      // steady stream over the last stretch
      if (p >= PHASES - 2) sender_gaps = 1'b0;
      repeat (ITEM_COUNT / PHASES) send_guesses(pick_guess(span), pick_guess(span));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_guesses();
    test_limit_status();
    test_tolerance_extremes();
    test_offset_extremes();
    test_long_runs();
    test_random_phases();

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Sent %0d guess pairs under %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("Outcomes: %0d converged, %0d small denominator, %0d iteration limit",
             status_hits[int'(srf_pkg::STAT_CONVERGED)],
             status_hits[int'(srf_pkg::STAT_SMALL_DENOM)],
             status_hits[int'(srf_pkg::STAT_LIMIT)]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== secant_root_finder.f =====
hdl/srf_pkg.sv
hdl/srf_mdu.sv
hdl/srf_seq.sv
hdl/secant_root_finder.sv
verif/tb_secant_root_finder.sv
